FILE: hdl/etf_pkg.sv
// ============================================================================
// etf_pkg: shared definitions for the escape-time fractal iterator
// Widths, reset values, command and register codes, sequencer states and the
// load-control group passed from the sequencer to the datapath.
// ============================================================================
package etf_pkg;

   // Default coordinate width (Q4.28 at 32 bits) and reported count width.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int ITER_WIDTH_DEF  = 16;

   // Integer bits of the fixed-point coordinate format, sign included.
   localparam int INT_BITS = 4;

   // Register and counter widths.
   localparam int CNT_WIDTH       = 16;
   localparam int COLOR_WIDTH     = 32;
   localparam int JULIA_WIDTH     = 32;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 2;

   // Widest operand digit that the shared multiplier handles at a time.
   localparam int DIGIT_MAX = 32;

   localparam logic [CNT_WIDTH-1:0]   MAX_ITER_RESET = 16'd100;
   localparam logic [COLOR_WIDTH-1:0] COLOR_RESET    = 32'h00FF_FFFF;

   typedef enum logic [1:0] {
      CMD_MANDELBROT   = 2'd0,
      CMD_JULIA        = 2'd1,
      CMD_TRICORN      = 2'd2,
      CMD_BURNING_SHIP = 2'd3
   } etf_cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_ITERATIONS = 2'd0,
      CSR_COLOR_CODE     = 2'd1,
      CSR_JULIA_C_RE     = 2'd2,
      CSR_JULIA_C_IM     = 2'd3
   } etf_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOP,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CHECK,
      ST_CROSS,
      ST_UPDATE,
      ST_UPD_IM,
      ST_COLOR
   } etf_state_type;

   // Operand pair routed into the shared multiplier.
   typedef enum logic [1:0] {
      MSEL_RE_SQ,
      MSEL_IM_SQ,
      MSEL_CROSS
   } etf_msel_type;

   // Register load strobes issued by the sequencer.
   typedef struct packed {
      logic ld_start;
      logic ld_sq_re;
      logic ld_sq_im;
      logic ld_check;
      logic ld_cross;
      logic ld_update;
      logic ld_upd_im;
      logic ld_rsp;
   } etf_load_type;

endpackage

FILE: hdl/etf_mul.sv
// ============================================================================
// etf_mul: shared digit-serial unsigned multiplier
// Multiplies two magnitudes one digit pair per cycle and accumulates the
// shifted partial products. The done strobe comes with the full product.
// ============================================================================
module etf_mul #(
   parameter int OP_WIDTH = etf_pkg::COORD_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [OP_WIDTH-1:0]     op_a,
   input  logic [OP_WIDTH-1:0]     op_b,
   output logic                    done,
   output logic [2*OP_WIDTH-1:0]   product
);

   localparam int DIG_WIDTH  = (OP_WIDTH > etf_pkg::DIGIT_MAX) ? etf_pkg::DIGIT_MAX : OP_WIDTH;
   localparam int NUM_DIGITS = (OP_WIDTH + DIG_WIDTH - 1) / DIG_WIDTH;
   localparam int PAD_WIDTH  = NUM_DIGITS * DIG_WIDTH;
   localparam int ACC_WIDTH  = 2 * PAD_WIDTH;
   localparam int IDX_WIDTH  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(NUM_DIGITS - 1);

   logic                   busy_ff, busy_in;
   logic [PAD_WIDTH-1:0]   a_ff, a_in;
   logic [PAD_WIDTH-1:0]   b_ff, b_in;
   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [IDX_WIDTH-1:0]   ia_ff, ia_in;
   logic [IDX_WIDTH-1:0]   ib_ff, ib_in;

   logic [DIG_WIDTH-1:0]   a_dig;
   logic [DIG_WIDTH-1:0]   b_dig;
   logic [2*DIG_WIDTH-1:0] partial;
   logic [ACC_WIDTH-1:0]   partial_shifted;
   logic [ACC_WIDTH-1:0]   acc_sum;
   logic                   last_step;

   // One digit pair per cycle; the partial product lands at its digit weight.
   always_comb begin
      a_dig           = a_ff[ia_ff * DIG_WIDTH +: DIG_WIDTH];
      b_dig           = b_ff[ib_ff * DIG_WIDTH +: DIG_WIDTH];
      partial         = a_dig * b_dig;
      partial_shifted = ACC_WIDTH'(partial) << (DIG_WIDTH * (int'(ia_ff) + int'(ib_ff)));
      acc_sum         = acc_ff + partial_shifted;
      last_step       = (ia_ff == LAST_IDX) && (ib_ff == LAST_IDX);
   end

   assign done    = busy_ff && last_step;
   assign product = acc_sum[2*OP_WIDTH-1:0];

   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      ia_in   = ia_ff;
      ib_in   = ib_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = PAD_WIDTH'(op_a);
         b_in    = PAD_WIDTH'(op_b);
         acc_in  = '0;
         ia_in   = '0;
         ib_in   = '0;
      end else if (busy_ff) begin
         acc_in = acc_sum;
         if (last_step) begin
            busy_in = 1'b0;
         end
         if (ia_ff == LAST_IDX) begin
            ia_in = '0;
            ib_in = ib_ff + 1'b1;
         end else begin
            ia_in = ia_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      ia_ff  <= ia_in;
      ib_ff  <= ib_in;
   end

endmodule

FILE: hdl/escape_time_fractal_iterator.sv
// ============================================================================
// escape_time_fractal_iterator: escape-time iteration for one pixel
// Iterates z = z*z + c in signed fixed point for Mandelbrot and Julia, and the
// tricorn and burning-ship variants; returns the iteration count and a colour word.
// ============================================================================
// The block takes one pixel transaction at a time and is not ready while it
// works on it. Every product goes through one shared multiplier that handles
// one digit pair of up to 32 bits per cycle and sums the partial products.
// One full iteration needs three products (zr squared, zi squared, zr times
// zi) plus the escape test and the two coordinate updates. A pixel that
// escapes also runs the two squares and the escape test of the iteration in
// which it escapes before its result is offered. The result sits in an
// output register, so the block finishes a pixel even while the previous
// result still waits; it only stalls in the colour state if that register
// is still full. Configuration registers may be written only while no
// transaction is in flight.
// ============================================================================
module escape_time_fractal_iterator #(
   parameter int COORD_WIDTH = etf_pkg::COORD_WIDTH_DEF,
   parameter int ITER_WIDTH  = etf_pkg::ITER_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel: one pixel per transaction.
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic signed [COORD_WIDTH-1:0]         req_point_re,
   input  logic signed [COORD_WIDTH-1:0]         req_point_im,
   // Response channel: one result per transaction.
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ITER_WIDTH-1:0]                 rsp_iterations,
   output logic [etf_pkg::COLOR_WIDTH-1:0]       rsp_pixel_color,
   // Configuration write port.
   input  logic                                  csr_write_enable,
   input  logic [etf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [etf_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   // Number format: COORD_WIDTH bits with FRAC fraction bits.
   localparam int FRAC    = COORD_WIDTH - etf_pkg::INT_BITS;
   // Products of two magnitudes, and their sum or difference with a sign bit.
   localparam int PROD_W  = 2 * COORD_WIDTH;
   localparam int SUM_W   = PROD_W + 1;
   // Shifted cross-term magnitude and the pre-saturation coordinate sums.
   localparam int MAG_W   = COORD_WIDTH + 5;
   localparam int SAT_W   = COORD_WIDTH + 6;
   // 2*zr*zi is the product shifted by one bit less than FRAC.
   localparam int X_SHIFT = FRAC - 1;
   localparam int CNT_W   = etf_pkg::CNT_WIDTH;
   localparam int COLOR_W = etf_pkg::COLOR_WIDTH;

   localparam logic [SUM_W-1:0] ONE_SUM    = SUM_W'(1);
   // 4.0 at 2*FRAC fraction bits.
   localparam logic [SUM_W-1:0] ESC_LIMIT  = ONE_SUM << (2 * FRAC + 2);
   // Added before the shift to round a negative cross term toward minus infinity.
   localparam logic [SUM_W-1:0] X_BIAS     = (ONE_SUM << X_SHIFT) - ONE_SUM;
   localparam logic [SAT_W-1:0] ONE_SAT    = SAT_W'(1);
   localparam logic signed [SAT_W-1:0] COORD_MAX = (ONE_SAT << (COORD_WIDTH - 1)) - ONE_SAT;
   localparam logic signed [SAT_W-1:0] COORD_MIN = ~COORD_MAX;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [CNT_W-1:0]                  max_iter_ff, max_iter_in;
   logic [COLOR_W-1:0]                color_code_ff, color_code_in;
   logic [etf_pkg::JULIA_WIDTH-1:0]   julia_re_ff, julia_re_in;
   logic [etf_pkg::JULIA_WIDTH-1:0]   julia_im_ff, julia_im_in;

   always_comb begin
      max_iter_in   = max_iter_ff;
      color_code_in = color_code_ff;
      julia_re_in   = julia_re_ff;
      julia_im_in   = julia_im_ff;
      if (csr_write_enable) begin
         case (etf_pkg::etf_csr_type'(csr_index))
            etf_pkg::CSR_MAX_ITERATIONS: max_iter_in   = csr_write_data[CNT_W-1:0];
            etf_pkg::CSR_COLOR_CODE:     color_code_in = csr_write_data[COLOR_W-1:0];
            etf_pkg::CSR_JULIA_C_RE:     julia_re_in   = csr_write_data[etf_pkg::JULIA_WIDTH-1:0];
            etf_pkg::CSR_JULIA_C_IM:     julia_im_in   = csr_write_data[etf_pkg::JULIA_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff   <= etf_pkg::MAX_ITER_RESET;
         color_code_ff <= etf_pkg::COLOR_RESET;
         julia_re_ff   <= '0;
         julia_im_ff   <= '0;
      end else begin
         max_iter_ff   <= max_iter_in;
         color_code_ff <= color_code_in;
         julia_re_ff   <= julia_re_in;
         julia_im_ff   <= julia_im_in;
      end
   end

   // The Julia constant is a 32-bit word. A narrower coordinate keeps its low
   // bits; a wider one takes the word as a non-negative value.
   logic signed [COORD_WIDTH-1:0] julia_re_coord;
   logic signed [COORD_WIDTH-1:0] julia_im_coord;

   generate
      if (COORD_WIDTH <= etf_pkg::JULIA_WIDTH) begin : g_julia_narrow
         assign julia_re_coord = julia_re_ff[COORD_WIDTH-1:0];
         assign julia_im_coord = julia_im_ff[COORD_WIDTH-1:0];
      end else begin : g_julia_wide
         assign julia_re_coord = {{(COORD_WIDTH - etf_pkg::JULIA_WIDTH){1'b0}}, julia_re_ff};
         assign julia_im_coord = {{(COORD_WIDTH - etf_pkg::JULIA_WIDTH){1'b0}}, julia_im_ff};
      end
   endgenerate

   // ------------------------------------------------------------------------
   // Working registers
   // ------------------------------------------------------------------------
   etf_pkg::etf_state_type        state_ff, state_in;
   etf_pkg::etf_cmd_type          kind_ff, kind_in;
   logic signed [COORD_WIDTH-1:0] zr_ff, zr_in;
   logic signed [COORD_WIDTH-1:0] zi_ff, zi_in;
   logic signed [COORD_WIDTH-1:0] cr_ff, cr_in;
   logic signed [COORD_WIDTH-1:0] ci_ff, ci_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [PROD_W-1:0]             p_re_ff, p_re_in;
   logic [PROD_W-1:0]             p_im_ff, p_im_in;
   logic signed [SUM_W-1:0]       d_ff, d_in;
   logic                          xneg_ff, xneg_in;
   logic [PROD_W-1:0]             x_mag_ff, x_mag_in;
   logic [MAG_W-1:0]              t_mag_ff, t_mag_in;
   logic                          t_neg_ff, t_neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ITER_WIDTH-1:0]         rsp_iter_ff, rsp_iter_in;
   logic [COLOR_W-1:0]            rsp_color_ff, rsp_color_in;

   // ------------------------------------------------------------------------
   // Shared multiplier and its operand routing
   // ------------------------------------------------------------------------
   logic [COORD_WIDTH-1:0] zr_abs;
   logic [COORD_WIDTH-1:0] zi_abs;
   logic [COORD_WIDTH-1:0] mul_a;
   logic [COORD_WIDTH-1:0] mul_b;
   logic                   mul_start;
   logic                   mul_done;
   logic [PROD_W-1:0]      mul_product;
   etf_pkg::etf_msel_type  mul_sel;

   always_comb begin
      zr_abs = zr_ff[COORD_WIDTH-1] ? (~zr_ff + 1'b1) : zr_ff;
      zi_abs = zi_ff[COORD_WIDTH-1] ? (~zi_ff + 1'b1) : zi_ff;
      case (mul_sel)
         etf_pkg::MSEL_RE_SQ: begin
            mul_a = zr_abs;
            mul_b = zr_abs;
         end
         etf_pkg::MSEL_IM_SQ: begin
            mul_a = zi_abs;
            mul_b = zi_abs;
         end
         etf_pkg::MSEL_CROSS: begin
            mul_a = zr_abs;
            mul_b = zi_abs;
         end
         default: begin
            mul_a = zr_abs;
            mul_b = zr_abs;
         end
      endcase
   end

   etf_mul #(
      .OP_WIDTH (COORD_WIDTH)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   // ------------------------------------------------------------------------
   // Decisions taken by the sequencer
   // ------------------------------------------------------------------------
   logic [SUM_W-1:0]  sq_sum;
   logic              bounded;
   logic [CNT_W:0]    cnt_next;
   logic              more_iter;

   always_comb begin
      // |z|^2 at 2*FRAC fraction bits is exact; burning ship also keeps
      // iterating on the boundary itself.
      sq_sum = {1'b0, p_re_ff} + {1'b0, p_im_ff};
      if (kind_ff == etf_pkg::CMD_BURNING_SHIP) begin
         bounded = (sq_sum <= ESC_LIMIT);
      end else begin
         bounded = (sq_sum < ESC_LIMIT);
      end
      cnt_next  = {1'b0, count_ff} + 1'b1;
      more_iter = (cnt_next < {1'b0, max_iter_ff});
   end

   // ------------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         etf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = etf_pkg::ST_LOOP;
            end
         end
         etf_pkg::ST_LOOP: begin
            // A zero limit runs no iteration at all.
            if (count_ff < max_iter_ff) begin
               state_in = etf_pkg::ST_SQ_RE;
            end else begin
               state_in = etf_pkg::ST_COLOR;
            end
         end
         etf_pkg::ST_SQ_RE: begin
            if (mul_done) begin
               state_in = etf_pkg::ST_SQ_IM;
            end
         end
         etf_pkg::ST_SQ_IM: begin
            if (mul_done) begin
               state_in = etf_pkg::ST_CHECK;
            end
         end
         etf_pkg::ST_CHECK: begin
            if (bounded) begin
               state_in = etf_pkg::ST_CROSS;
            end else begin
               state_in = etf_pkg::ST_COLOR;
            end
         end
         etf_pkg::ST_CROSS: begin
            if (mul_done) begin
               state_in = etf_pkg::ST_UPDATE;
            end
         end
         etf_pkg::ST_UPDATE: begin
            state_in = etf_pkg::ST_UPD_IM;
         end
         etf_pkg::ST_UPD_IM: begin
            if (more_iter) begin
               state_in = etf_pkg::ST_SQ_RE;
            end else begin
               state_in = etf_pkg::ST_COLOR;
            end
         end
         etf_pkg::ST_COLOR: begin
            // Wait only if the previous result has not been taken yet.
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = etf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = etf_pkg::ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer: outputs
   // ------------------------------------------------------------------------
   etf_pkg::etf_load_type load;

   always_comb begin
      load      = '0;
      req_ready = 1'b0;
      mul_start = 1'b0;
      mul_sel   = etf_pkg::MSEL_RE_SQ;
      case (state_ff)
         etf_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            load.ld_start = req_valid;
         end
         etf_pkg::ST_LOOP: begin
            mul_start = (count_ff < max_iter_ff);
            mul_sel   = etf_pkg::MSEL_RE_SQ;
         end
         etf_pkg::ST_SQ_RE: begin
            // Back-to-back: zi squared starts as soon as zr squared is out.
            load.ld_sq_re = mul_done;
            mul_start     = mul_done;
            mul_sel       = etf_pkg::MSEL_IM_SQ;
         end
         etf_pkg::ST_SQ_IM: begin
            load.ld_sq_im = mul_done;
         end
         etf_pkg::ST_CHECK: begin
            load.ld_check = bounded;
            mul_start     = bounded;
            mul_sel       = etf_pkg::MSEL_CROSS;
         end
         etf_pkg::ST_CROSS: begin
            load.ld_cross = mul_done;
         end
         etf_pkg::ST_UPDATE: begin
            load.ld_update = 1'b1;
         end
         etf_pkg::ST_UPD_IM: begin
            // zr already holds its new value, so any next iteration starts here.
            load.ld_upd_im = 1'b1;
            mul_start      = more_iter;
            mul_sel        = etf_pkg::MSEL_RE_SQ;
         end
         etf_pkg::ST_COLOR: begin
            load.ld_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Coordinate update arithmetic
   // ------------------------------------------------------------------------
   logic signed [SAT_W-1:0]       re_sum;
   logic signed [COORD_WIDTH-1:0] re_sat;
   logic [SUM_W-1:0]              x_biased;
   logic signed [SAT_W-1:0]       ci_ext;
   logic signed [SAT_W-1:0]       mag_ext;
   logic signed [SAT_W-1:0]       im_sum;
   logic signed [COORD_WIDTH-1:0] im_sat;

   always_comb begin
      // New real part: floor((zr^2 - zi^2) / 2^FRAC) + c_re, saturated.
      re_sum = SAT_W'($signed(d_ff[SUM_W-1:FRAC])) + SAT_W'(cr_ff);
      if (re_sum > COORD_MAX) begin
         re_sat = COORD_MAX[COORD_WIDTH-1:0];
      end else if (re_sum < COORD_MIN) begin
         re_sat = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         re_sat = re_sum[COORD_WIDTH-1:0];
      end

      // Magnitude of 2*zr*zi rounded toward minus infinity: a negative
      // value rounds its magnitude up.
      x_biased = {1'b0, x_mag_ff} + (xneg_ff ? X_BIAS : '0);

      // New imaginary part: c_im plus or minus the cross-term magnitude.
      ci_ext  = SAT_W'(ci_ff);
      mag_ext = SAT_W'(t_mag_ff);
      im_sum  = t_neg_ff ? (ci_ext - mag_ext) : (ci_ext + mag_ext);
      if (im_sum > COORD_MAX) begin
         im_sat = COORD_MAX[COORD_WIDTH-1:0];
      end else if (im_sum < COORD_MIN) begin
         im_sat = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         im_sat = im_sum[COORD_WIDTH-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Result: count and colour
   // ------------------------------------------------------------------------
   logic [CNT_W:0]          iter_sum;
   logic [COLOR_W-1:0]      color_scale;
   logic [COLOR_W-1:0]      color_prod;
   logic [COLOR_W-1:0]      color_val;
   logic [ITER_WIDTH-1:0]   iter_report;

   always_comb begin
      iter_sum    = {1'b0, count_ff} + {1'b0, max_iter_ff};
      color_scale = COLOR_W'(iter_sum);
      color_prod  = color_code_ff * color_scale;
      color_val   = (count_ff == max_iter_ff) ? color_code_ff : color_prod;
   end

   // A narrow count port reports the count modulo its width.
   generate
      if (ITER_WIDTH <= CNT_W) begin : g_iter_narrow
         assign iter_report = count_ff[ITER_WIDTH-1:0];
      end else begin : g_iter_wide
         assign iter_report = {{(ITER_WIDTH - CNT_W){1'b0}}, count_ff};
      end
   endgenerate

   // ------------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------------
   always_comb begin
      kind_in      = kind_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      count_in     = count_ff;
      p_re_in      = p_re_ff;
      p_im_in      = p_im_ff;
      d_in         = d_ff;
      xneg_in      = xneg_ff;
      x_mag_in     = x_mag_ff;
      t_mag_in     = t_mag_ff;
      t_neg_in     = t_neg_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_color_in = rsp_color_ff;
      rsp_valid_in = rsp_valid_ff;

      if (load.ld_start) begin
         kind_in  = etf_pkg::etf_cmd_type'(req_command);
         count_in = '0;
         if (etf_pkg::etf_cmd_type'(req_command) == etf_pkg::CMD_JULIA) begin
            zr_in = req_point_re;
            zi_in = req_point_im;
            cr_in = julia_re_coord;
            ci_in = julia_im_coord;
         end else begin
            zr_in = '0;
            zi_in = '0;
            cr_in = req_point_re;
            ci_in = req_point_im;
         end
      end
      if (load.ld_sq_re) begin
         p_re_in = mul_product;
      end
      if (load.ld_sq_im) begin
         p_im_in = mul_product;
      end
      if (load.ld_check) begin
         d_in    = $signed({1'b0, p_re_ff}) - $signed({1'b0, p_im_ff});
         xneg_in = zr_ff[COORD_WIDTH-1] ^ zi_ff[COORD_WIDTH-1];
      end
      if (load.ld_cross) begin
         // The multiplier has latched its operands, so zr may move on now.
         x_mag_in = mul_product;
         zr_in    = re_sat;
      end
      if (load.ld_update) begin
         t_mag_in = x_biased[X_SHIFT +: MAG_W];
         case (kind_ff)
            etf_pkg::CMD_TRICORN:      t_neg_in = !xneg_ff;
            etf_pkg::CMD_BURNING_SHIP: t_neg_in = 1'b0;
            default:                   t_neg_in = xneg_ff;
         endcase
      end
      if (load.ld_upd_im) begin
         zi_in    = im_sat;
         count_in = cnt_next[CNT_W-1:0];
      end

      if (load.ld_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_iter_in  = iter_report;
         rsp_color_in = color_val;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      count_ff     <= count_in;
      p_re_ff      <= p_re_in;
      p_im_ff      <= p_im_in;
      d_ff         <= d_in;
      xneg_ff      <= xneg_in;
      x_mag_ff     <= x_mag_in;
      t_mag_ff     <= t_mag_in;
      t_neg_ff     <= t_neg_in;
      rsp_iter_ff  <= rsp_iter_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_iterations  = rsp_iter_ff;
   assign rsp_pixel_color = rsp_color_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // A new result only ever appears out of the colour state.
   a_rsp_from_color: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == etf_pkg::ST_COLOR))
      else $error("result appeared outside the colour state");

   // Every multiplier start is followed by a state that waits for its product.
   a_start_waits: assert property (@(posedge clock) disable iff (reset)
      mul_start |=> (state_ff == etf_pkg::ST_SQ_RE || state_ff == etf_pkg::ST_SQ_IM ||
                     state_ff == etf_pkg::ST_CROSS))
      else $error("multiplier started without a waiting state");

   // A finished product is never dropped: it arrives only in a waiting state.
   a_done_consumed: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == etf_pkg::ST_SQ_RE || state_ff == etf_pkg::ST_SQ_IM ||
                    state_ff == etf_pkg::ST_CROSS))
      else $error("multiplier product arrived with nobody waiting for it");

endmodule

FILE: verif/escape_time_fractal_iterator_test.sv
`timescale 1ns / 1ps
// ============================================================================
// escape_time_fractal_iterator_test: self-checking bench for the iterator
// Drives pixel transactions in all four fractal modes and predicts each
// iteration count and colour word in Q4.28 arithmetic. Every response is
// checked against the oldest prediction; both channels idle at random outside one steady phase.
// ============================================================================
module escape_time_fractal_iterator_test;

   localparam int FRAC = etf_pkg::COORD_WIDTH_DEF - etf_pkg::INT_BITS;

   // Ends of the signed coordinate range and a few Q4.28 anchors.
   localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam int                 Q_ONE      = 268435456;
   localparam int                 NEAR_RANGE = 603979776;   // 2.25

   // Wide copies of the range ends, used when saturating a new coordinate.
   localparam logic signed [127:0] WIDE_MAX = 128'sd2147483647;
   localparam logic signed [127:0] WIDE_MIN = -128'sd2147483648;

   // Run limit for a hung test. Only two directed points run under the
   // largest limit of 65535 iterations; the random pixels use limits of at
   // most 255 iterations.
   localparam int LIMIT_CYCLES = 4_000_000;

   // Cycles to let pass once the last response has arrived.
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [etf_pkg::ITER_WIDTH_DEF-1:0] iterations;
      logic [etf_pkg::COLOR_WIDTH-1:0]    pixel_color;
   } pixel_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [1:0]                          req_command = etf_pkg::CMD_MANDELBROT;
   logic signed [31:0]                  req_point_re = '0;
   logic signed [31:0]                  req_point_im = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic [etf_pkg::ITER_WIDTH_DEF-1:0]  rsp_iterations;
   logic [etf_pkg::COLOR_WIDTH-1:0]     rsp_pixel_color;
   logic                                csr_write_enable = 1'b0;
   logic [etf_pkg::CSR_INDEX_WIDTH-1:0] csr_index = etf_pkg::CSR_MAX_ITERATIONS;
   logic [etf_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   // Our own copy of the configuration registers, at their reset values.
   logic [etf_pkg::CNT_WIDTH-1:0]       cfg_max_iterations = etf_pkg::MAX_ITER_RESET;
   logic [etf_pkg::COLOR_WIDTH-1:0]     cfg_color_code     = etf_pkg::COLOR_RESET;
   logic signed [31:0]                  cfg_julia_re       = '0;
   logic signed [31:0]                  cfg_julia_im       = '0;

   pixel_result_type expected_pixels[$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   bit               steady_flow    = 1'b0;   // when set, neither side idles

   escape_time_fractal_iterator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_point_re     (req_point_re),
      .req_point_im     (req_point_im),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_iterations   (rsp_iterations),
      .rsp_pixel_color  (rsp_pixel_color),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // Give up if the run hangs, for example on a lost response.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The response side stalls at random with a chance of nine in a hundred,
   // except during the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= steady_flow || ($urandom_range(99) >= 9);
   end

   // Converts a real number to Q4.28 for the directed points.
   function automatic logic signed [31:0] to_q428(input real value);
      return $rtoi(value * 268435456.0);
   endfunction

   // Clamps a wide intermediate value to the 32-bit coordinate range.
   function automatic logic signed [31:0] saturate_coord(input logic signed [127:0] value);
      if (value > WIDE_MAX) return COORD_MAX;
      if (value < WIDE_MIN) return COORD_MIN;
      return value[31:0];
   endfunction

   // Escape-time iteration for one pixel under the current configuration.
   // Squares are exact at 56 fraction bits; the new real part floors
   // (zr^2 - zi^2) back to 28 bits, the new imaginary part floors 2*zr*zi.
   function automatic pixel_result_type predict_pixel(input etf_pkg::etf_cmd_type cmd,
                                                       input logic signed [31:0] point_re,
                                                       input logic signed [31:0] point_im);
      logic signed [31:0]  zr, zi, cr, ci;
      logic signed [127:0] wr, wi, sq_re, sq_im, radius_sq, cross_term, four;
      logic [63:0]         product;
      int unsigned         count;
      bit                  bounded;
      pixel_result_type    result;
      four = 128'sd1 <<< (2 * FRAC + 2);
      if (cmd == etf_pkg::CMD_JULIA) begin
         zr = point_re;
         zi = point_im;
         cr = cfg_julia_re;
         ci = cfg_julia_im;
      end else begin
         zr = '0;
         zi = '0;
         cr = point_re;
         ci = point_im;
      end
      count = 0;
      while (count < cfg_max_iterations) begin
         wr        = zr;
         wi        = zi;
         sq_re     = wr * wr;
         sq_im     = wi * wi;
         radius_sq = sq_re + sq_im;
         // Burning ship keeps going on the circle itself; the others stop.
         if (cmd == etf_pkg::CMD_BURNING_SHIP) bounded = (radius_sq <= four);
         else                                  bounded = (radius_sq < four);
         if (!bounded) break;
         cross_term = (wr * wi) >>> (FRAC - 1);
         if (cmd == etf_pkg::CMD_TRICORN) begin
            cross_term = -cross_term;
         end else if (cmd == etf_pkg::CMD_BURNING_SHIP && cross_term < 0) begin
            cross_term = -cross_term;
         end
         zi = saturate_coord(cross_term + 128'(ci));
         zr = saturate_coord(((sq_re - sq_im) >>> FRAC) + 128'(cr));
         count++;
      end
      result.iterations = count[etf_pkg::ITER_WIDTH_DEF-1:0];
      if (count == cfg_max_iterations) begin
         result.pixel_color = cfg_color_code;
      end else begin
         product = 64'(cfg_color_code) * 64'(count + 32'(cfg_max_iterations));
         result.pixel_color = product[31:0];
      end
      return result;
   endfunction

   // Mostly points near the sets, where iteration runs long, with some
   // points anywhere in the full 32-bit range.
   function automatic logic signed [31:0] random_coord();
      if ($urandom_range(99) < 15) return $urandom;
      return $signed($urandom_range(2 * NEAR_RANGE)) - NEAR_RANGE;
   endfunction

   // Sends one pixel transaction, idling beforehand at random. The
   // prediction is queued once the transaction is accepted. Enters and
   // leaves at a falling edge; valid stays high for a following item.
   task automatic send_pixel(input etf_pkg::etf_cmd_type cmd,
                             input logic signed [31:0] point_re,
                             input logic signed [31:0] point_im);
      pixel_result_type want;
      want = predict_pixel(cmd, point_re, point_im);
      while (!steady_flow && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_point_re <= point_re;
      req_point_im <= point_im;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(want);
      @(negedge clock);
   endtask

   // Drops valid and waits until every predicted response has arrived, then
   // lets the settle time pass so that the block is surely idle.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input etf_pkg::etf_csr_type index, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
   endtask

   // Writes all four registers back to back and updates our copy. Called
   // only while the block is idle.
   task automatic configure(input logic [15:0] max_iter, input logic [31:0] color,
                            input logic signed [31:0] c_re, input logic signed [31:0] c_im);
      write_register(etf_pkg::CSR_MAX_ITERATIONS, 32'(max_iter));
      write_register(etf_pkg::CSR_COLOR_CODE, color);
      write_register(etf_pkg::CSR_JULIA_C_RE, c_re);
      write_register(etf_pkg::CSR_JULIA_C_IM, c_im);
      csr_write_enable   <= 1'b0;
      cfg_max_iterations  = max_iter;
      cfg_color_code      = color;
      cfg_julia_re        = c_re;
      cfg_julia_im        = c_im;
      @(negedge clock);
   endtask

   // Response checker: each accepted response against the oldest prediction.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("response transaction with no pixel outstanding: iterations %0d color %h",
                   rsp_iterations, rsp_pixel_color);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_iterations !== want.iterations) begin
               $error("iterations: expected %0d, actual %0d", want.iterations, rsp_iterations);
               mismatch_count++;
            end
            if (rsp_pixel_color !== want.pixel_color) begin
               $error("pixel_color: expected %h, actual %h", want.pixel_color, rsp_pixel_color);
               mismatch_count++;
            end
         end
      end
   end

   // Nothing is written here, so these pixels run with the reset values:
   // a limit of 100, white as colour and a Julia constant of zero.
   task automatic test_reset_values();
      send_pixel(etf_pkg::CMD_MANDELBROT, '0, '0);
      send_pixel(etf_pkg::CMD_JULIA, to_q428(0.5), to_q428(0.5));
      send_pixel(etf_pkg::CMD_BURNING_SHIP, to_q428(-0.5), to_q428(0.5));
      settle_block();
   endtask

   // Points whose orbit lands exactly on the circle of radius two. Burning
   // ship keeps iterating there while the other modes escape, and a Julia
   // start point on the circle escapes before the first iteration.
   task automatic test_escape_boundary();
      configure(16'd20, 32'h0055_AA33, '0, '0);
      send_pixel(etf_pkg::CMD_MANDELBROT, to_q428(2.0), '0);
      send_pixel(etf_pkg::CMD_BURNING_SHIP, to_q428(2.0), '0);
      send_pixel(etf_pkg::CMD_MANDELBROT, to_q428(-2.0), '0);
      send_pixel(etf_pkg::CMD_BURNING_SHIP, to_q428(-2.0), '0);
      send_pixel(etf_pkg::CMD_JULIA, '0, to_q428(2.0));
      settle_block();
   endtask

   // Both ends of the coordinate range in every mode.
   task automatic test_field_extremes();
      configure(16'd7, 32'hA5A5_5A5A, to_q428(0.25), to_q428(-0.5));
      for (int cmd = etf_pkg::CMD_MANDELBROT; cmd <= etf_pkg::CMD_BURNING_SHIP; cmd++) begin
         send_pixel(etf_pkg::etf_cmd_type'(cmd), COORD_MIN, COORD_MIN);
         send_pixel(etf_pkg::etf_cmd_type'(cmd), COORD_MAX, COORD_MAX);
      end
      settle_block();
   endtask

   // Julia constants at the range ends push the next coordinate past the
   // range, so each part has to saturate at both ends.
   task automatic test_saturation();
      configure(16'd4, 32'h0000_0003, COORD_MAX, COORD_MIN);
      send_pixel(etf_pkg::CMD_JULIA, to_q428(1.9), '0);
      send_pixel(etf_pkg::CMD_JULIA, to_q428(1.4), to_q428(-1.4));
      settle_block();
      configure(16'd4, 32'h8000_0001, COORD_MIN, COORD_MAX);
      send_pixel(etf_pkg::CMD_JULIA, '0, to_q428(1.9));
      send_pixel(etf_pkg::CMD_JULIA, to_q428(1.4), to_q428(1.4));
      settle_block();
   endtask

   // A limit of zero runs no iteration at all, so every pixel takes the
   // inside colour. Then the smallest real limit, and last the largest,
   // where one inside point takes the full 65535 iterations.
   task automatic test_limit_extremes();
      configure(16'd0, 32'hFFFF_FFFF, '0, '0);
      send_pixel(etf_pkg::CMD_MANDELBROT, '0, '0);
      send_pixel(etf_pkg::CMD_JULIA, COORD_MAX, COORD_MAX);
      settle_block();
      configure(16'd1, 32'h0000_0000, to_q428(-1.0), to_q428(1.0));
      send_pixel(etf_pkg::CMD_MANDELBROT, '0, '0);
      send_pixel(etf_pkg::CMD_TRICORN, to_q428(1.0), to_q428(1.0));
      settle_block();
      configure(16'hFFFF, 32'h0102_0304, '0, '0);
      send_pixel(etf_pkg::CMD_MANDELBROT, '0, '0);
      send_pixel(etf_pkg::CMD_MANDELBROT, to_q428(-0.75), to_q428(0.1));
      settle_block();
   endtask

   // Random pixels in eight phases, each under its own configuration. One
   // phase runs without idling on either side, and one uses a longer limit.
   task automatic test_random_pixels(input int total);
      logic [15:0]        max_iter;
      logic signed [31:0] c_re, c_im;
      for (int phase = 0; phase < 8; phase++) begin
         max_iter = (phase == 5) ? 16'd255 : 16'($urandom_range(64, 1));
         c_re = $signed($urandom_range(2 * Q_ONE)) - Q_ONE;
         c_im = $signed($urandom_range(2 * Q_ONE)) - Q_ONE;
         configure(max_iter, $urandom, c_re, c_im);
         steady_flow = (phase == 2);
         repeat (total / 8) begin
            send_pixel(etf_pkg::etf_cmd_type'($urandom_range(3)), random_coord(),
                       random_coord());
         end
         settle_block();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      // Synchronous reset, released at a falling edge; every later step of
      // the test also starts at a falling edge.
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_escape_boundary();
      test_field_extremes();
      test_saturation();
      test_limit_extremes();
      test_random_pixels(400);

      // All transactions are in and answered; let the block run out.
      settle_block();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/etf_pkg.sv
hdl/etf_mul.sv
hdl/escape_time_fractal_iterator.sv
verif/escape_time_fractal_iterator_test.sv
